// File: rtl/core/outlier_gated_running_average_defines.svh
// assertion helpers for the running average block
`ifndef OUTLIER_GATED_RUNNING_AVERAGE_DEFINES_SVH
`define OUTLIER_GATED_RUNNING_AVERAGE_DEFINES_SVH

// implication checked on every edge outside reset
`define OGRA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define OGRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ogra_pkg.sv
`timescale 1ns / 1ps
package ogra_pkg;
  localparam int unsigned SampleW = 16;
  localparam int unsigned CntW = 4;
  localparam logic [CntW-1:0] CntMax = 4'd15;
  localparam logic [SampleW-1:0] SqrtTopBit = 16'h8000;
  localparam int unsigned SqrtSteps = 16;

  typedef enum logic [1:0] {
    CLS_ACCEPTED = 2'd0,
    CLS_OUTLIER  = 2'd1,
    CLS_INVALID  = 2'd2,
    CLS_RESTART  = 2'd3
  } sample_class_t;

  typedef enum logic [1:0] {
    CFG_MULT     = 2'd0,
    CFG_MIN_DEV  = 2'd1,
    CFG_FAIL_LIM = 2'd2,
    CFG_OUT_LIM  = 2'd3
  } cfg_index_t;

  // handshake between the sequencer and the shared divider
  typedef struct packed {
    logic start;
    logic [63:0] dividend;
    logic [5:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [63:0] quotient;
  } div_rsp_t;
endpackage

// File: rtl/core/outlier_gated_running_average.sv
`timescale 1ns / 1ps
// Outlier-gated running average. One sample beat in, one result beat out.
// The sample rings for history and accepted values live in two single-port
// synchronous memories; a nonzero sample outside a restart walks the history
// ring one entry per cycle to sum mean and squared deviation, then runs
// 64-step divisions on a shared bit-serial divider and a 16-step square root.
// An accepted sample takes three divisions and also walks the accepted ring;
// an outlier takes two; both take fewer while the history ring is empty.
// Invalid and restart items are resolved in the decode state and go straight
// to the output register. One item is in flight at a time: the next sample is
// taken the cycle after the previous result beat leaves the output register,
// so a stalled receiver stalls the input.
module outlier_gated_running_average
  import ogra_pkg::*;
#(
  parameter int unsigned ACCEPT_DEPTH  = 8,
  parameter int unsigned HISTORY_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SampleW-1:0]  in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SampleW-1:0]  out_filtered_avg,
  output logic [1:0]          out_sample_class,
  output logic                out_restart_armed,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  `include "outlier_gated_running_average_defines.svh"

  localparam int unsigned AW = (ACCEPT_DEPTH > 1) ? $clog2(ACCEPT_DEPTH) : 1;
  localparam int unsigned HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned ACW = $clog2(ACCEPT_DEPTH + 1);
  localparam int unsigned HCW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [AW-1:0] ALast = AW'(ACCEPT_DEPTH - 1);
  localparam logic [HW-1:0] HLast = HW'(HISTORY_DEPTH - 1);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_DEC   = 11'b00000000010,
    ST_HSUM  = 11'b00000000100,
    ST_HMEAN = 11'b00000001000,
    ST_HVAR  = 11'b00000010000,
    ST_HVDIV = 11'b00000100000,
    ST_SQRT  = 11'b00001000000,
    ST_CMP   = 11'b00010000000,
    ST_ASUM  = 11'b00100000000,
    ST_ADIV  = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [3:0]  mult_r, fail_lim_r, out_lim_r;
  logic [15:0] min_dev_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r <= 4'd2;
      min_dev_r <= 16'd16;
      fail_lim_r <= 4'd3;
      out_lim_r <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MULT:     mult_r <= cfg_wdata[3:0];
        CFG_MIN_DEV:  min_dev_r <= cfg_wdata;
        CFG_FAIL_LIM: fail_lim_r <= cfg_wdata[3:0];
        CFG_OUT_LIM:  out_lim_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // ring memories
  logic [SampleW-1:0] hmem [HISTORY_DEPTH];
  logic [SampleW-1:0] amem [ACCEPT_DEPTH];
  logic [SampleW-1:0] hrd_r, ard_r;
  logic          hwe, awe;
  logic [HW-1:0] haddr;
  logic [AW-1:0] aaddr;
  logic [SampleW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (hwe) hmem[haddr] <= wdata;
    hrd_r <= hmem[haddr];
  end
  always_ff @(posedge clk) begin
    if (awe) amem[aaddr] <= wdata;
    ard_r <= amem[aaddr];
  end

  // control and item state
  logic [AW-1:0]  aptr_r, aptr_nxt;
  logic [ACW-1:0] acnt_r, acnt_nxt;
  logic [HW-1:0]  hptr_r, hptr_nxt;
  logic [HCW-1:0] hcnt_r, hcnt_nxt;
  logic [15:0]    avg_r, avg_nxt;
  logic           rflag_r, rflag_nxt;
  logic [3:0]     fcnt_r, fcnt_nxt, ocnt_r, ocnt_nxt;
  logic [15:0]    smp_r, smp_nxt;
  logic [5:0]     idx_r, idx_nxt;
  logic [5:0]     rdv_r, rdv_nxt;
  logic [63:0]    acc_r, acc_nxt;
  logic [15:0]    mean_r, mean_nxt;
  logic [15:0]    root_r, root_nxt;
  logic [15:0]    bit_r, bit_nxt;
  logic [3:0]     sh_r, sh_nxt;
  logic           ov_r, ov_nxt;
  logic [15:0]    oavg_r, oavg_nxt;
  logic [1:0]     ocls_r, ocls_nxt;
  logic           oarm_r, oarm_nxt;

  div_req_t dreq;
  div_rsp_t drsp;
  ogra_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [16:0] dabs;
  logic [31:0] sq;
  logic [63:0] sqt;
  logic [15:0] dev, diff;
  logic [19:0] lim;

  always_comb begin
    state_nxt = state_r;
    aptr_nxt = aptr_r; acnt_nxt = acnt_r; hptr_nxt = hptr_r; hcnt_nxt = hcnt_r;
    avg_nxt = avg_r; rflag_nxt = rflag_r; fcnt_nxt = fcnt_r; ocnt_nxt = ocnt_r;
    smp_nxt = smp_r; idx_nxt = idx_r; rdv_nxt = rdv_r; acc_nxt = acc_r;
    mean_nxt = mean_r; root_nxt = root_r; bit_nxt = bit_r; sh_nxt = sh_r;
    ov_nxt = ov_r; oavg_nxt = oavg_r; ocls_nxt = ocls_r; oarm_nxt = oarm_r;
    hwe = 1'b0; awe = 1'b0; haddr = idx_r[HW-1:0]; aaddr = idx_r[AW-1:0];
    wdata = smp_r;
    dreq.start = 1'b0; dreq.dividend = acc_r; dreq.divisor = rdv_r;
    dabs = (hrd_r >= mean_r) ? {1'b0, hrd_r - mean_r} : {1'b0, mean_r - hrd_r};
    sq = dabs[15:0] * dabs[15:0];
    sqt = ({47'd0, root_r, 1'b0} + {48'd0, bit_r}) << sh_r;
    dev = (root_r < min_dev_r) ? min_dev_r : root_r;
    diff = (smp_r >= avg_r) ? smp_r - avg_r : avg_r - smp_r;
    lim = {16'd0, mult_r} * {4'd0, dev};
    if (out_valid && out_ready) ov_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          smp_nxt = in_sample;
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        if (avg_r == 16'd0 || rflag_r) begin
          // restart step
          rflag_nxt = 1'b0; fcnt_nxt = '0; ocnt_nxt = '0;
          if (smp_r != 16'd0) begin
            awe = 1'b1; aaddr = '0;
            aptr_nxt = (ALast == '0) ? '0 : AW'(1);
            acnt_nxt = ACW'(1);
            avg_nxt = smp_r;
            hwe = 1'b1; haddr = hptr_r;
            hptr_nxt = (hptr_r == HLast) ? '0 : hptr_r + HW'(1);
            if (hcnt_r != HCW'(HISTORY_DEPTH)) hcnt_nxt = hcnt_r + HCW'(1);
            oavg_nxt = smp_r; oarm_nxt = 1'b0;
          end else begin
            aptr_nxt = '0; acnt_nxt = '0; avg_nxt = '0;
            oavg_nxt = '0; oarm_nxt = 1'b1;
          end
          ocls_nxt = CLS_RESTART; ov_nxt = 1'b1; state_nxt = ST_OUT;
        end else if (smp_r == 16'd0) begin
          fcnt_nxt = (fcnt_r == CntMax) ? fcnt_r : fcnt_r + 4'd1;
          if (fcnt_nxt == fail_lim_r || ocnt_r >= out_lim_r) rflag_nxt = 1'b1;
          oavg_nxt = avg_r; ocls_nxt = CLS_INVALID;
          oarm_nxt = (fcnt_nxt == fail_lim_r || ocnt_r >= out_lim_r);
          ov_nxt = 1'b1; state_nxt = ST_OUT;
        end else begin
          acc_nxt = '0; idx_nxt = '0; haddr = '0;
          mean_nxt = '0; root_nxt = '0;
          state_nxt = (hcnt_r == '0) ? ST_CMP : ST_HSUM;
        end
      end
      // walk history: read issued at idx, data arrives the next cycle
      ST_HSUM: begin
        if (idx_r != '0) acc_nxt = acc_r + {48'd0, hrd_r};
        if (idx_r == 6'(hcnt_r)) begin
          rdv_nxt = 6'(hcnt_r);
          dreq.start = 1'b1; dreq.dividend = acc_nxt; dreq.divisor = 6'(hcnt_r);
          state_nxt = ST_HMEAN;
        end else begin
          haddr = idx_r[HW-1:0]; idx_nxt = idx_r + 6'd1;
        end
      end
      ST_HMEAN: begin
        haddr = '0;
        if (drsp.done) begin
          mean_nxt = drsp.quotient[15:0];
          acc_nxt = '0; idx_nxt = 6'd1;
          state_nxt = ST_HVAR;
        end
      end
      ST_HVAR: begin
        acc_nxt = acc_r + {32'd0, sq};
        if (idx_r == 6'(hcnt_r)) begin
          dreq.start = 1'b1; dreq.dividend = acc_nxt;
          state_nxt = ST_HVDIV;
        end else begin
          haddr = idx_r[HW-1:0]; idx_nxt = idx_r + 6'd1;
        end
      end
      ST_HVDIV: begin
        if (drsp.done) begin
          acc_nxt = drsp.quotient;
          root_nxt = '0; bit_nxt = SqrtTopBit; sh_nxt = 4'd15; idx_nxt = '0;
          state_nxt = ST_SQRT;
        end
      end
      // one root bit per cycle
      ST_SQRT: begin
        if (acc_r >= sqt) begin
          root_nxt = root_r + bit_r; acc_nxt = acc_r - sqt;
        end
        bit_nxt = bit_r >> 1;
        if (sh_r != 4'd0) sh_nxt = sh_r - 4'd1;
        if (bit_r == 16'd1) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        hwe = 1'b1; haddr = hptr_r;
        hptr_nxt = (hptr_r == HLast) ? '0 : hptr_r + HW'(1);
        if (hcnt_r != HCW'(HISTORY_DEPTH)) hcnt_nxt = hcnt_r + HCW'(1);
        if ({4'd0, diff} > lim) begin
          ocnt_nxt = (ocnt_r == CntMax) ? ocnt_r : ocnt_r + 4'd1;
          oavg_nxt = avg_r; ocls_nxt = CLS_OUTLIER; oarm_nxt = rflag_r;
          ov_nxt = 1'b1; state_nxt = ST_OUT;
        end else begin
          awe = 1'b1; aaddr = aptr_r;
          if (acnt_r != ACW'(ACCEPT_DEPTH)) acnt_nxt = acnt_r + ACW'(1);
          aptr_nxt = (aptr_r == ALast) ? '0 : aptr_r + AW'(1);
          fcnt_nxt = '0; ocnt_nxt = '0;
          acc_nxt = '0; idx_nxt = '0;
          state_nxt = ST_ASUM;
        end
      end
      ST_ASUM: begin
        if (idx_r != '0) acc_nxt = acc_r + {48'd0, ard_r};
        if (idx_r == 6'(acnt_r)) begin
          rdv_nxt = 6'(acnt_r);
          dreq.start = 1'b1; dreq.dividend = acc_nxt; dreq.divisor = 6'(acnt_r);
          state_nxt = ST_ADIV;
        end else begin
          aaddr = idx_r[AW-1:0]; idx_nxt = idx_r + 6'd1;
        end
      end
      ST_ADIV: begin
        if (drsp.done) begin
          avg_nxt = drsp.quotient[15:0];
          oavg_nxt = drsp.quotient[15:0]; ocls_nxt = CLS_ACCEPTED;
          oarm_nxt = rflag_r || (drsp.quotient[15:0] == 16'd0);
          ov_nxt = 1'b1; state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    smp_r <= smp_nxt; idx_r <= idx_nxt; rdv_r <= rdv_nxt; acc_r <= acc_nxt;
    mean_r <= mean_nxt; root_r <= root_nxt; bit_r <= bit_nxt; sh_r <= sh_nxt;
    oavg_r <= oavg_nxt; ocls_r <= ocls_nxt; oarm_r <= oarm_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      aptr_r <= '0; acnt_r <= '0; hptr_r <= '0; hcnt_r <= '0;
      avg_r <= '0; rflag_r <= 1'b1; fcnt_r <= '0; ocnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      aptr_r <= aptr_nxt; acnt_r <= acnt_nxt; hptr_r <= hptr_nxt; hcnt_r <= hcnt_nxt;
      avg_r <= avg_nxt; rflag_r <= rflag_nxt; fcnt_r <= fcnt_nxt; ocnt_r <= ocnt_nxt;
      ov_r <= ov_nxt;
    end
  end

  // take a new beat only once the output register is free
  assign in_ready = (state_r == ST_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_filtered_avg = oavg_r;
  assign out_sample_class = ocls_r;
  assign out_restart_armed = oarm_r;

  `OGRA_ASSERT_IMPL(a_hcnt_range, 1'b1, hcnt_r <= HCW'(HISTORY_DEPTH), "history count overflow")
  `OGRA_ASSERT_IMPL(a_acnt_range, 1'b1, acnt_r <= ACW'(ACCEPT_DEPTH), "accepted count overflow")
  `OGRA_ASSERT_IMPL(a_arm_zero, out_valid && out_filtered_avg == 16'd0, out_restart_armed,
                    "zero average not flagged")
  `OGRA_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "second beat accepted")
endmodule

// File: rtl/core/ogra_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module ogra_div
  import ogra_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  `include "outlier_gated_running_average_defines.svh"

  logic [63:0] quo_r, quo_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic [5:0]  dvs_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [6:0]  trial;

  // shift one dividend bit into the partial remainder
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[5:0], quo_r[63]};
    if (req.start) begin
      quo_nxt = req.dividend;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) dvs_r <= req.divisor;
    if (!rst_n) begin
      cnt_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quotient = quo_r;

  `OGRA_ASSERT_IMPL(a_div_done_idle, done_r, !busy_r, "divider done while busy")
  `OGRA_ASSERT_NEXT(a_div_start_busy, req.start, busy_r, "divider failed to start")
  `OGRA_ASSERT_IMPL(a_div_cnt_busy, busy_r, cnt_r != 7'd0, "divider count empty while busy")
endmodule
